[rtl/core/sclbs_pkg.sv]
// Package for the status code LED blink sequencer.
// Word types, status codes and the blink pattern ROM; no dependencies.

package sclbs_pkg;

  localparam int unsigned CodeW    = 4;
  localparam int unsigned ElapsedW = 13;
  localparam int unsigned PhaseW   = 11;
  localparam int unsigned IndexW   = 4;
  localparam int unsigned MsW      = 10;

  localparam logic [CodeW-1:0] CODE_NONE = 4'd0;
  localparam logic [CodeW-1:0] CODE_OK   = 4'd1;

  localparam logic [7:0] GAP_TICKS = 8'd10;

  localparam logic [ElapsedW-1:0] ELAPSED_MAX = 13'd8191;
  localparam logic [23:0]         OK_COLOUR   = 24'h006400;

  typedef struct packed {
    logic             req_type;
    logic [CodeW-1:0] code;
  } in_word_t;

  typedef struct packed {
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic [CodeW-1:0] active_code;
  } out_word_t;

  typedef struct packed {
    logic                valid;
    logic [2:0]          blinks;
    logic [MsW-1:0]      on_ms;
    logic [MsW-1:0]      off_ms;
    logic [ElapsedW-1:0] window_ms;
    logic [23:0]         colour;
  } pattern_t;

  // Blink pattern rows for codes 2..12; other codes read an invalid row.
  function automatic pattern_t pattern_row(input logic [CodeW-1:0] code);
    pattern_t row;
    row = '0;
    unique case (code)
      4'd2:    row = '{1'b1, 3'd3, 10'd200,  10'd200, 13'd3000, 24'h00ff00};
      4'd3:    row = '{1'b1, 3'd1, 10'd500,  10'd500, 13'd5000, 24'hffff00};
      4'd4:    row = '{1'b1, 3'd1, 10'd1000, 10'd0,   13'd500,  24'h003700};
      4'd5:    row = '{1'b1, 3'd5, 10'd100,  10'd100, 13'd3000, 24'hff0000};
      4'd6:    row = '{1'b1, 3'd2, 10'd300,  10'd300, 13'd3000, 24'h0000ff};
      4'd7:    row = '{1'b1, 3'd2, 10'd300,  10'd300, 13'd3000, 24'h9b0000};
      4'd8:    row = '{1'b1, 3'd1, 10'd1000, 10'd0,   13'd1000, 24'h0000ff};
      4'd9:    row = '{1'b1, 3'd3, 10'd250,  10'd250, 13'd3000, 24'hff0000};
      4'd10:   row = '{1'b1, 3'd4, 10'd150,  10'd150, 13'd3000, 24'hffa500};
      4'd11:   row = '{1'b1, 3'd6, 10'd100,  10'd100, 13'd3000, 24'hff00ff};
      4'd12:   row = '{1'b1, 3'd6, 10'd100,  10'd100, 13'd3000, 24'h0000ff};
      default: row = '0;
    endcase
    return row;
  endfunction

endpackage

[rtl/core/sclbs_core.sv]
// Sequencer state and its per-word update: ticks, pending requests, phases.
// Depends on sclbs_pkg for codes, widths and the pattern ROM.

module sclbs_core import sclbs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  in_word_t  word_i,
  output out_word_t result_o
);

  logic [CodeW-1:0]    current_q, current_d;
  logic [CodeW-1:0]    pending_q, pending_d;
  logic                pend_vld_q, pend_vld_d;
  logic [ElapsedW-1:0] elapsed_q, elapsed_d;
  logic [PhaseW-1:0]   remain_q, remain_d;
  logic [IndexW-1:0]   index_q, index_d;
  logic [23:0]         colour_q, colour_d;

  logic [CodeW-1:0]    cur_code;
  logic [ElapsedW-1:0] el_base;
  logic [IndexW-1:0]   idx_base;
  logic [11:0]         phase_len;
  pattern_t            row;
  logic                in_seq;

  always_comb begin
    current_d  = current_q;
    pending_d  = pending_q;
    pend_vld_d = pend_vld_q;
    elapsed_d  = elapsed_q;
    remain_d   = remain_q;
    index_d    = index_q;
    colour_d   = colour_q;
    cur_code   = pend_vld_q ? pending_q : current_q;
    el_base    = pend_vld_q ? '0 : elapsed_q;
    idx_base   = pend_vld_q ? '0 : index_q;
    row        = pattern_row(cur_code);
    in_seq     = row.valid && (el_base < row.window_ms)
                 && ({1'b0, idx_base} < {1'b0, row.blinks, 1'b0});
    phase_len  = {4'd0, GAP_TICKS};

    if (step_i) begin
      if (word_i.req_type) begin
        pending_d  = word_i.code;
        pend_vld_d = 1'b1;
      end else begin
        if (remain_q != '0) begin
          remain_d = remain_q - 1'b1;
          el_base  = elapsed_q;
        end else begin
          // phase boundary: adopt pending code, then pick the next phase
          current_d  = cur_code;
          pend_vld_d = 1'b0;
          index_d    = idx_base;
          if (cur_code == CODE_NONE) begin
            colour_d = '0;
          end else if (cur_code == CODE_OK) begin
            colour_d = OK_COLOUR;
          end else if (in_seq) begin
            if (!idx_base[0]) begin
              colour_d  = row.colour;
              phase_len = {2'd0, row.on_ms} + {4'd0, GAP_TICKS};
            end else begin
              colour_d  = '0;
              phase_len = {2'd0, row.off_ms} + {4'd0, GAP_TICKS};
            end
            index_d = idx_base + 1'b1;
          end else begin
            // finished, window passed or unknown code: back to ok
            current_d = CODE_OK;
          end
          remain_d = (phase_len == '0) ? '0 : PhaseW'(phase_len - 12'd1);
        end
        elapsed_d = (el_base == ELAPSED_MAX) ? el_base : el_base + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      current_q  <= CODE_OK;
      pending_q  <= CODE_NONE;
      pend_vld_q <= 1'b0;
      elapsed_q  <= '0;
      remain_q   <= '0;
      index_q    <= '0;
      colour_q   <= '0;
    end else begin
      current_q  <= current_d;
      pending_q  <= pending_d;
      pend_vld_q <= pend_vld_d;
      elapsed_q  <= elapsed_d;
      remain_q   <= remain_d;
      index_q    <= index_d;
      colour_q   <= colour_d;
    end
  end

  assign result_o = '{red:         colour_d[23:16],
                      green:       colour_d[15:8],
                      blue:        colour_d[7:0],
                      active_code: current_d};

  // an unknown code never stays on display
  a_status_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    current_q <= 4'd12)
    else $error("active status outside pattern range");

  // phase index never passes twice the largest blink count
  a_index_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    index_q <= 4'd12)
    else $error("phase index out of range");

  // a boundary tick always consumes the pending request
  a_boundary_takes_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && !word_i.req_type && remain_q == '0) |=> !pend_vld_q)
    else $error("pending request survived a phase boundary");

  // a request alone leaves the display untouched
  a_req_keeps_led: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && word_i.req_type) |=> ($stable(colour_q) && $stable(current_q)))
    else $error("request changed the LED state");

endmodule

[rtl/core/status_code_led_blink_sequencer.sv]
// Top level of the status code LED blink sequencer.
// Input word register, sequencer core and result register; uses sclbs_pkg.

// Takes one word per clock (a 1 ms tick or a status code request) and returns
// one result word per input word: the LED colour and the code being shown after
// that word. Each word is registered in the input register and then in the result
// register; the update itself is a single pass of short logic in sclbs_core, so
// one word is taken every cycle while the output is not stalled.
// No clearing pass after reset. Requests wait for the next phase boundary and
// only the last one before it counts.

module status_code_led_blink_sequencer import sclbs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_data_o
);

  logic      in_valid_q;
  in_word_t  in_data_q;
  logic      out_valid_q;
  out_word_t out_data_q;
  out_word_t result;
  logic      advance;
  logic      step;

  assign advance    = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o) begin
      in_data_q <= in_data_i;
    end
    if (step) begin
      out_data_q <= result;
    end
  end

  sclbs_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .word_i   (in_data_q),
    .result_o (result)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // a held input word is never dropped while the output is stalled
  a_hold_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> in_valid_q)
    else $error("input word lost under stall");

  // every word leaving the input register lands in the result register
  a_step_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_valid_q)
    else $error("result word not registered");

  // a stalled result word keeps its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> (out_valid_q && $stable(out_data_q)))
    else $error("stalled result word changed");

endmodule
